@@ src/tes_pkg.sv @@
// Shared types and constants for the text encoding sniffer.
package tes_pkg;

    typedef enum logic [2:0] {
        CLS_EMPTY   = 3'd0,
        CLS_UTF8    = 3'd1,
        CLS_UTF16LE = 3'd2,
        CLS_UTF16BE = 3'd3,
        CLS_EUCKR   = 3'd4,
        CLS_ANSI    = 3'd5
    } class_t;

    localparam logic [7:0] BOM8_B0     = 8'hEF;
    localparam logic [7:0] BOM8_B1     = 8'hBB;
    localparam logic [7:0] BOM8_B2     = 8'hBF;
    localparam logic [7:0] BOM16_FF    = 8'hFF;
    localparam logic [7:0] BOM16_FE    = 8'hFE;

    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;

    localparam logic [7:0] KR_LEAD_LO  = 8'hB0;
    localparam logic [7:0] KR_LEAD_HI  = 8'hC8;
    localparam logic [7:0] KR_WIDE_LO  = 8'h81;
    localparam logic [7:0] KR_WIDE_HI  = 8'hFE;
    localparam logic [7:0] KR_TRAIL_LO = 8'h41;
    localparam logic [7:0] KR_TRAIL_HI = 8'hFE;

    localparam int EXAMINED_W = 11;

    typedef struct packed {
        logic       has_byte;
        logic       has_two;
        logic       has_three;
        logic [7:0] head0;
        logic [7:0] head1;
        logic [7:0] head2;
        logic       utf8_valid;
        logic       multibyte;
        logic       korean_pair;
    } scan_status_t;

endpackage

@@ src/tes_scan.sv @@
// Per-file scan state: byte count, head bytes, UTF-8 tracking and EUC-KR pair detection.
module tes_scan #(
    parameter int SAMPLE_BYTES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [7:0]                          data_byte,
    input  logic                                carries_byte,
    input  logic                                end_of_file,
    output tes_pkg::scan_status_t               status,
    output logic [tes_pkg::EXAMINED_W-1:0]      examined
);
    import tes_pkg::*;

    localparam int POS_W = $clog2(SAMPLE_BYTES + 1);
    localparam int EXT_W = (POS_W > EXAMINED_W) ? POS_W : EXAMINED_W;

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    logic [7:0]       head_reg [3];
    logic [7:0]       head_next [3];
    logic [7:0]       head_upd [3];
    logic [7:0]       prev_reg, prev_next, prev_upd;
    logic [1:0]       pend_reg, pend_next, pend_upd;
    logic             valid_reg, valid_next, valid_upd;
    logic             multi_reg, multi_next, multi_upd;
    logic             kr_reg, kr_next, kr_upd;
    logic             take;
    logic [EXT_W-1:0] pos_ext;

    function automatic logic korean_pair(input logic [7:0] p, input logic [7:0] c);
        logic narrow;
        logic wide;
        narrow = (p >= KR_LEAD_LO) && (p <= KR_LEAD_HI);
        wide   = (p >= KR_WIDE_LO) && (p <= KR_WIDE_HI)
              && (c >= KR_TRAIL_LO) && (c <= KR_TRAIL_HI);
        return narrow || wide;
    endfunction

    assign take = carries_byte && (pos_reg < POS_W'(SAMPLE_BYTES));

    // fold the incoming byte into the scan state
    always_comb
    begin
        pos_upd   = pos_reg;
        head_upd  = head_reg;
        prev_upd  = prev_reg;
        pend_upd  = pend_reg;
        valid_upd = valid_reg;
        multi_upd = multi_reg;
        kr_upd    = kr_reg;
        if (take)
        begin
            if (pos_reg == POS_W'(0))
                head_upd[0] = data_byte;
            if (pos_reg == POS_W'(1))
                head_upd[1] = data_byte;
            if (pos_reg == POS_W'(2))
                head_upd[2] = data_byte;
            if ((pos_reg != POS_W'(0)) && korean_pair(prev_reg, data_byte))
                kr_upd = 1'b1;
            if (valid_reg)
            begin
                if (pend_reg != 2'd0)
                begin
                    if ((data_byte & CONT_MASK) != CONT_CODE)
                        valid_upd = 1'b0;
                    else
                        pend_upd = pend_reg - 2'd1;
                end
                else if (data_byte[7])
                begin
                    multi_upd = 1'b1;
                    if ((data_byte & LEAD2_MASK) == LEAD2_CODE)
                        pend_upd = 2'd1;
                    else if ((data_byte & LEAD3_MASK) == LEAD3_CODE)
                        pend_upd = 2'd2;
                    else if ((data_byte & LEAD4_MASK) == LEAD4_CODE)
                        pend_upd = 2'd3;
                    else
                        valid_upd = 1'b0;
                end
            end
            prev_upd = data_byte;
            pos_upd  = pos_reg + POS_W'(1);
        end
    end

    // clear for the next file once the last word is done
    always_comb
    begin
        pos_next   = pos_reg;
        head_next  = head_reg;
        prev_next  = prev_reg;
        pend_next  = pend_reg;
        valid_next = valid_reg;
        multi_next = multi_reg;
        kr_next    = kr_reg;
        if (step)
        begin
            if (end_of_file)
            begin
                pos_next   = '0;
                head_next  = '{8'h00, 8'h00, 8'h00};
                prev_next  = 8'h00;
                pend_next  = 2'd0;
                valid_next = 1'b1;
                multi_next = 1'b0;
                kr_next    = 1'b0;
            end
            else
            begin
                pos_next   = pos_upd;
                head_next  = head_upd;
                prev_next  = prev_upd;
                pend_next  = pend_upd;
                valid_next = valid_upd;
                multi_next = multi_upd;
                kr_next    = kr_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            head_reg  <= '{8'h00, 8'h00, 8'h00};
            prev_reg  <= 8'h00;
            pend_reg  <= 2'd0;
            valid_reg <= 1'b1;
            multi_reg <= 1'b0;
            kr_reg    <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            head_reg  <= head_next;
            prev_reg  <= prev_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            multi_reg <= multi_next;
            kr_reg    <= kr_next;
        end
    end

    assign status.has_byte    = (pos_upd != POS_W'(0));
    assign status.has_two     = (pos_upd >= POS_W'(2));
    assign status.has_three   = (pos_upd >= POS_W'(3));
    assign status.head0       = head_upd[0];
    assign status.head1       = head_upd[1];
    assign status.head2       = head_upd[2];
    assign status.utf8_valid  = valid_upd;
    assign status.multibyte   = multi_upd;
    assign status.korean_pair = kr_upd;

    assign pos_ext  = EXT_W'(pos_upd);
    assign examined = pos_ext[EXAMINED_W-1:0];

endmodule

@@ src/tes_classify.sv @@
// Class decision from the final scan status of one file.
module tes_classify (
    input  tes_pkg::scan_status_t status,
    output tes_pkg::class_t       enc_class
);
    import tes_pkg::*;

    always_comb
    begin
        if (!status.has_byte)
            enc_class = CLS_EMPTY;
        else if (status.has_three && (status.head0 == BOM8_B0)
                 && (status.head1 == BOM8_B1) && (status.head2 == BOM8_B2))
            enc_class = CLS_UTF8;
        else if (status.has_two && (status.head0 == BOM16_FF) && (status.head1 == BOM16_FE))
            enc_class = CLS_UTF16LE;
        else if (status.has_two && (status.head0 == BOM16_FE) && (status.head1 == BOM16_FF))
            enc_class = CLS_UTF16BE;
        else if (status.utf8_valid && status.multibyte)
            enc_class = CLS_UTF8;
        else if (status.korean_pair)
            enc_class = CLS_EUCKR;
        else
            enc_class = CLS_ANSI;
    end

endmodule

@@ src/text_encoding_sniffer_unit.sv @@
// Top level of the text encoding sniffer: input register, scan, classify, result register.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_ready  | data_byte, carries_byte, end_of_file
//  out     | out_valid/out_ready| encoding_class, bytes_examined
//
// One word per cycle enters the input register unless a stalled result holds it; the scan
// state updates from a word as it leaves that register, so each word passes it before it counts.
// A word with end_of_file loads the result register the same cycle and clears the
// scan state for the next file. Reset leaves both registers empty and the scan clear.
// A stalled result holds the input register only while it holds a last word.
module text_encoding_sniffer_unit #(
    parameter int SAMPLE_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        carries_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  encoding_class,
    output logic [10:0] bytes_examined
);
    import tes_pkg::*;

    logic                  s1_valid_reg, s1_valid_next;
    logic [7:0]            s1_byte_reg;
    logic                  s1_carries_reg;
    logic                  s1_eof_reg;
    logic                  s1_fire;
    logic                  out_free;
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            class_reg;
    logic [EXAMINED_W-1:0] examined_reg;
    scan_status_t          status;
    class_t                enc_class;
    logic [EXAMINED_W-1:0] examined;

    assign out_free      = !out_valid_reg || out_ready;
    assign s1_fire       = s1_valid_reg && (!s1_eof_reg || out_free);
    assign in_ready      = !s1_valid_reg || s1_fire;
    assign s1_valid_next = (in_valid && in_ready) || (s1_valid_reg && !s1_fire);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_fire && s1_eof_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg    <= data_byte;
            s1_carries_reg <= carries_byte;
            s1_eof_reg     <= end_of_file;
        end
        if (s1_fire && s1_eof_reg)
        begin
            class_reg    <= enc_class;
            examined_reg <= examined;
        end
    end

    tes_scan #(
        .SAMPLE_BYTES (SAMPLE_BYTES)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_fire),
        .data_byte    (s1_byte_reg),
        .carries_byte (s1_carries_reg),
        .end_of_file  (s1_eof_reg),
        .status       (status),
        .examined     (examined)
    );

    tes_classify u_classify (
        .status    (status),
        .enc_class (enc_class)
    );

    assign out_valid      = out_valid_reg;
    assign encoding_class = class_reg;
    assign bytes_examined = examined_reg;

endmodule

@@ test/sniffer_checker.sv @@
// Checker for the text encoding sniffer: predicts each file's class and compares results.
module sniffer_checker #(
    parameter int SAMPLE_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        carries_byte,
    input  logic        end_of_file,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  encoding_class,
    input  logic [10:0] bytes_examined,
    output int          mismatches,
    output int          verdicts_waiting
);
    import tes_pkg::*;

    typedef struct packed {
        class_t      cls;
        logic [10:0] examined;
    } verdict_t;

    verdict_t    pending_verdicts[$];

    int unsigned sampled;
    logic [7:0]  head[3];
    logic [7:0]  last_byte;
    logic [1:0]  conts_owed;
    logic        utf8_ok;
    logic        lead_seen;
    logic        pair_seen;

    function automatic logic korean_pair(input logic [7:0] p, input logic [7:0] c);
        return (p >= KR_LEAD_LO && p <= KR_LEAD_HI) ||
               (p >= KR_WIDE_LO && p <= KR_WIDE_HI && c >= KR_TRAIL_LO && c <= KR_TRAIL_HI);
    endfunction

    function void clear_scan();
        sampled    = 0;
        head       = '{default: 8'h00};
        last_byte  = 8'h00;
        conts_owed = 2'd0;
        utf8_ok    = 1'b1;
        lead_seen  = 1'b0;
        pair_seen  = 1'b0;
    endfunction

    function void scan_byte(input logic [7:0] b);
        if (sampled < 3)
        begin
            head[sampled] = b;
        end
        if (sampled > 0 && korean_pair(last_byte, b))
        begin
            pair_seen = 1'b1;
        end
        if (utf8_ok)
        begin
            if (conts_owed != 2'd0)
            begin
                if ((b & CONT_MASK) != CONT_CODE)
                    utf8_ok = 1'b0;
                else
                    conts_owed = conts_owed - 2'd1;
            end
            else if (b[7])
            begin
                lead_seen = 1'b1;
                if ((b & LEAD2_MASK) == LEAD2_CODE)
                    conts_owed = 2'd1;
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                    conts_owed = 2'd2;
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                    conts_owed = 2'd3;
                else
                    utf8_ok = 1'b0;
            end
        end
        last_byte = b;
        sampled++;
    endfunction

    function class_t file_class();
        if (sampled == 0)
            return CLS_EMPTY;
        if (sampled >= 3 && head[0] == BOM8_B0 && head[1] == BOM8_B1 && head[2] == BOM8_B2)
            return CLS_UTF8;
        if (sampled >= 2 && head[0] == BOM16_FF && head[1] == BOM16_FE)
            return CLS_UTF16LE;
        if (sampled >= 2 && head[0] == BOM16_FE && head[1] == BOM16_FF)
            return CLS_UTF16BE;
        if (utf8_ok && lead_seen)
            return CLS_UTF8;
        if (pair_seen)
            return CLS_EUCKR;
        return CLS_ANSI;
    endfunction

    always @(posedge clk)
    begin : watch
        verdict_t want;
        if (!rst_n)
        begin
            clear_scan();
            pending_verdicts.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("unexpected word on out: encoding_class=%0d bytes_examined=%0d",
                           encoding_class, bytes_examined);
                    mismatches++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (encoding_class !== want.cls)
                    begin
                        $error("encoding_class: expected %0d, got %0d", want.cls, encoding_class);
                        mismatches++;
                    end
                    if (bytes_examined !== want.examined)
                    begin
                        $error("bytes_examined: expected %0d, got %0d",
                               want.examined, bytes_examined);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (carries_byte && sampled < SAMPLE_BYTES)
                    scan_byte(data_byte);
                if (end_of_file)
                begin
                    want.cls      = file_class();
                    want.examined = 11'(sampled);
                    pending_verdicts.push_back(want);
                    clear_scan();
                end
            end
        end
        verdicts_waiting = pending_verdicts.size();
    end

endmodule

@@ test/testbench.sv @@
// Top of the text encoding sniffer test: clock, reset, file stimulus, receiver and verdict.
module testbench;
    import tes_pkg::*;

    localparam int SAMPLE_LEN = 1024;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte    = 8'h00;
    logic        carries_byte = 1'b0;
    logic        end_of_file  = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [2:0]  encoding_class;
    logic [10:0] bytes_examined;

    int          mismatches;
    int          verdicts_waiting;
    int          words_sent   = 0;
    bit          calm         = 1'b0;
    bit          sender_lazy  = 1'b0;
    bit          hold_request = 1'b0;
    logic [7:0]  file_bytes[$];

    text_encoding_sniffer_unit #(.SAMPLE_BYTES(SAMPLE_LEN)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .carries_byte   (carries_byte),
        .end_of_file    (end_of_file),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .encoding_class (encoding_class),
        .bytes_examined (bytes_examined)
    );

    sniffer_checker #(.SAMPLE_BYTES(SAMPLE_LEN)) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .carries_byte     (carries_byte),
        .end_of_file      (end_of_file),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .encoding_class   (encoding_class),
        .bytes_examined   (bytes_examined),
        .mismatches       (mismatches),
        .verdicts_waiting (verdicts_waiting)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, quiet stretches, one long hold-off
    initial
    begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
            end
            else if (calm)
            begin
                out_ready = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                out_ready = 1'b1;
                repeat (49) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic c, input logic e);
        if (!calm && sender_lazy && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid     = 1'b1;
        data_byte    = b;
        carries_byte = c;
        end_of_file  = e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_file(input bit split_end, input bit with_gaps);
        int i;
        if (file_bytes.size() == 0)
        begin
            send_word(8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (i = 0; i < file_bytes.size(); i++)
        begin
            if (with_gaps && $urandom_range(0, 7) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(file_bytes[i], 1'b1, (i == file_bytes.size() - 1) && !split_end);
        end
        if (split_end)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    function void push_utf8_char();
        int k;
        int j;
        k = $urandom_range(1, 4);
        case (k)
            1: file_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
            2: file_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            3: file_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            default: file_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
        endcase
        for (j = 1; j < k; j++)
            file_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endfunction

    function void build_file(input int kind, input int len);
        int          n;
        logic [7:0]  prefix[$];
        file_bytes.delete();
        if (len == 0)
            return;
        case (kind)
            0:
            begin
                while (file_bytes.size() < len)
                    push_utf8_char();
                // cut the last sequence short
                while (file_bytes.size() > len)
                    void'(file_bytes.pop_back());
            end
            1:
            begin
                while (file_bytes.size() < len)
                begin
                    if ($urandom_range(0, 2) == 0)
                        file_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        file_bytes.push_back(8'($urandom_range(8'hB0, 8'hC8)));
                        file_bytes.push_back(8'($urandom));
                    end
                    else
                    begin
                        file_bytes.push_back(8'($urandom_range(8'h81, 8'hFE)));
                        file_bytes.push_back(8'($urandom_range(8'h41, 8'hFE)));
                    end
                end
            end
            2:
            begin
                for (n = 0; n < len; n++)
                    file_bytes.push_back(8'($urandom));
            end
            3:
            begin
                case ($urandom_range(0, 2))
                    0: prefix = '{BOM8_B0, BOM8_B1, BOM8_B2};
                    1: prefix = '{BOM16_FF, BOM16_FE};
                    default: prefix = '{BOM16_FE, BOM16_FF};
                endcase
                if ($urandom_range(0, 3) == 0)
                    prefix[$urandom_range(0, prefix.size() - 1)] = 8'($urandom);
                n = $urandom_range(1, prefix.size());
                for (int j = 0; j < n; j++)
                    file_bytes.push_back(prefix[j]);
                for (int j = 1; j < len; j++)
                    file_bytes.push_back(8'($urandom));
            end
            default:
            begin
                for (n = 0; n < len; n++)
                    file_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
            end
        endcase
    endfunction

    function int pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 0;
        if (r < 55)
            return 1;
        if (r < 70)
            return 2;
        if (r < 85)
            return 3;
        return 4;
    endfunction

    initial
    begin : stimulus
        int file_no;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0);
        file_bytes = '{8'h41};
        send_file(1'b1, 1'b0);
        file_bytes = '{BOM8_B0, BOM8_B1, BOM8_B2};
        send_file(1'b0, 1'b0);
        file_bytes = '{BOM8_B0, BOM8_B1};
        send_file(1'b0, 1'b0);
        file_bytes = '{BOM16_FF, BOM16_FE};
        send_file(1'b0, 1'b0);
        file_bytes = '{BOM16_FE, BOM16_FF};
        send_file(1'b0, 1'b0);
        file_bytes = '{8'hC3, 8'hA9};
        send_file(1'b0, 1'b0);
        file_bytes = '{8'hB0, 8'h41};
        send_file(1'b0, 1'b0);
        file_bytes = '{8'h81, 8'hFE};
        send_file(1'b0, 1'b0);
        file_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80};
        send_file(1'b0, 1'b0);
        file_bytes = '{8'h00, 8'hFF};
        send_file(1'b0, 1'b0);

        file_no = 0;
        while (words_sent < 1950)
        begin
            if (words_sent > 1700)
                calm = 1'b1;
            sender_lazy = 1'($urandom_range(0, 1));
            if (file_no == 6)
                hold_request = 1'b1;
            if (file_no == 12)
                build_file($urandom_range(0, 2), SAMPLE_LEN + $urandom_range(1, 6));
            else if (file_no >= 6 && file_no < 30)
                build_file(pick_kind(), $urandom_range(0, 4));
            else
                build_file(pick_kind(), $urandom_range(0, 40));
            send_file($urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
            file_no++;
        end
        in_valid = 1'b0;

        while (verdicts_waiting != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
